// File: rtl/core/range_max_subarray_tree_core_defines.svh
// Assertion macros shared by the checker of range_max_subarray_tree_core.
// Uses clk and rst of the module that expands them.
`ifndef RANGE_MAX_SUBARRAY_TREE_CORE_DEFINES_SVH
`define RANGE_MAX_SUBARRAY_TREE_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define RMST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmst checker: property failed");

// next-cycle implication, off during reset
`define RMST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmst checker: property failed");

// next-cycle implication that also covers reset itself
`define RMST_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rmst checker: property failed");

`endif

// File: rtl/core/rmst_pkg.sv
// Shared types and constants for the range max-subarray segment tree.
// No dependencies.
`timescale 1ns / 1ps
package rmst_pkg;

  localparam int LEAF_COUNT_DEF = 1024;
  localparam int VALUE_BITS_DEF = 16;
  localparam int IDX_W          = 10;
  localparam int N_W            = 11;
  localparam int OUT_W          = 26;
  localparam logic [N_W-1:0] N_RESET = 11'd1024;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LEAF, ST_UP_A, ST_UP_B, ST_UP_W,
    ST_Q_LOOP, ST_Q_LEFT, ST_Q_RIGHT, ST_Q_DONE
  } state_t;

  typedef enum logic [2:0] {
    AS_CLEAR, AS_LEAF, AS_CHILD_A, AS_CHILD_B, AS_PARENT, AS_QL, AS_QR
  } addr_sel_t;

  typedef enum logic [1:0] {
    WS_ZERO, WS_LEAF, WS_MERGE
  } wsel_t;

  typedef struct packed {
    logic      capture;
    logic      clr_step;
    addr_sel_t addr_sel;
    logic      we;
    wsel_t     wsel;
    logic      lat_a;
    logic      p_init;
    logic      p_shift;
    logic      q_init;
    logic      q_shift;
    logic      l_merge;
    logic      r_merge;
    logic      out_load;
    logic      out_err;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind;
    logic load_oob;
    logic q_err;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic p_root;
  } status_t;

endpackage

// File: rtl/core/rmst_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/rmst_ctrl.sv
// Controller state machine: clearing pass, path update and range query.
// Depends on rmst_pkg.
`timescale 1ns / 1ps
module rmst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rmst_pkg::status_t st,
  output rmst_pkg::cmd_t    cmd
);
  import rmst_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (st.clr_last) state_next = ST_IDLE;
      ST_IDLE:     if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (!st.kind) begin
          state_next = st.load_oob ? ST_IDLE : ST_LEAF;
        end else begin
          state_next = st.q_err ? ST_IDLE : ST_Q_LOOP;
        end
      end
      ST_LEAF:     state_next = ST_UP_A;
      ST_UP_A:     state_next = ST_UP_B;
      ST_UP_B:     state_next = ST_UP_W;
      ST_UP_W:     state_next = st.p_root ? ST_IDLE : ST_UP_A;
      ST_Q_LOOP: begin
        if (!st.l_lt_r)  state_next = ST_Q_DONE;
        else if (st.l_odd) state_next = ST_Q_LEFT;
        else if (st.r_odd) state_next = ST_Q_RIGHT;
      end
      ST_Q_LEFT:   state_next = ST_Q_LOOP;
      ST_Q_RIGHT:  state_next = ST_Q_LOOP;
      ST_Q_DONE:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.addr_sel = AS_CLEAR;
    cmd.wsel     = WS_ZERO;
    case (state)
      ST_CLEAR: begin
        cmd.we       = 1'b1;
        cmd.clr_step = 1'b1;
      end
      ST_IDLE:     cmd.capture = start;
      ST_DISPATCH: begin
        cmd.p_init   = !st.kind;
        cmd.q_init   = st.kind;
        cmd.out_load = st.kind && st.q_err;
        cmd.out_err  = 1'b1;
      end
      ST_LEAF: begin
        cmd.addr_sel = AS_LEAF;
        cmd.we       = 1'b1;
        cmd.wsel     = WS_LEAF;
      end
      ST_UP_A:     cmd.addr_sel = AS_CHILD_A;
      ST_UP_B: begin
        cmd.addr_sel = AS_CHILD_B;
        cmd.lat_a    = 1'b1;
      end
      ST_UP_W: begin
        cmd.addr_sel = AS_PARENT;
        cmd.we       = 1'b1;
        cmd.wsel     = WS_MERGE;
        cmd.p_shift  = 1'b1;
      end
      ST_Q_LOOP: begin
        cmd.addr_sel = st.l_odd ? AS_QL : AS_QR;
        cmd.q_shift  = st.l_lt_r && !st.l_odd && !st.r_odd;
      end
      ST_Q_LEFT:   cmd.l_merge = 1'b1;
      ST_Q_RIGHT:  cmd.r_merge = 1'b1;
      ST_Q_DONE:   cmd.out_load = 1'b1;
      default:     cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);
endmodule

// File: rtl/core/rmst_dpath.sv
// Datapath: node RAM, merge unit, query cursors and result registers.
// Depends on rmst_pkg and rmst_ram.
`timescale 1ns / 1ps
module rmst_dpath #(
  parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF,
  parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rmst_pkg::cmd_t                      cmd,
  output rmst_pkg::status_t                   st,
  input  logic                                kind,
  input  logic [rmst_pkg::IDX_W-1:0]          index,
  input  logic signed [VALUE_BITS-1:0]        value,
  input  logic [rmst_pkg::IDX_W-1:0]          range_low,
  input  logic [rmst_pkg::IDX_W-1:0]          range_high,
  input  logic                                cfg_we,
  input  logic [rmst_pkg::N_W-1:0]            cfg_data,
  output logic                                done,
  output logic signed [rmst_pkg::OUT_W-1:0]   prefix_best,
  output logic signed [rmst_pkg::OUT_W-1:0]   suffix_best,
  output logic signed [rmst_pkg::OUT_W-1:0]   best_sum,
  output logic signed [rmst_pkg::OUT_W-1:0]   range_total,
  output logic                                range_error
);
  import rmst_pkg::*;

  localparam int LAW = $clog2(LEAF_COUNT);
  localparam int AW  = LAW + 1;
  localparam int QW  = LAW + 2;
  localparam int SW  = VALUE_BITS + LAW + 2;
  localparam int IW  = (LAW > IDX_W) ? LAW : IDX_W;
  localparam int CW  = (LAW + 1 > N_W) ? LAW + 1 : N_W;
  localparam int EW  = (SW > OUT_W) ? SW : OUT_W;
  localparam logic signed [EW-1:0] OMAX = EW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] OMIN = -OMAX - EW'(1);

  // span packing: {prefix, suffix, best, total}
  function automatic logic signed [SW-1:0] max2(input logic signed [SW-1:0] x,
                                                input logic signed [SW-1:0] y);
    max2 = (x > y) ? x : y;
  endfunction

  function automatic logic [4*SW-1:0] combine(input logic [4*SW-1:0] a,
                                              input logic [4*SW-1:0] b);
    logic signed [SW-1:0] ap, as, ab, at, bp, bs, bb, bt;
    {ap, as, ab, at} = a;
    {bp, bs, bb, bt} = b;
    combine = {max2(ap, at + bp), max2(bs, as + bt),
               max2(max2(ab, bb), as + bp), at + bt};
  endfunction

  function automatic logic [OUT_W-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [EW-1:0] xe;
    xe = EW'(x);
    if (xe > OMAX)      sat = OUT_W'(OMAX);
    else if (xe < OMIN) sat = OUT_W'(OMIN);
    else                sat = OUT_W'(xe);
  endfunction

  logic                        kind_q;
  logic [IDX_W-1:0]            index_q, lo_q, hi_q;
  logic signed [VALUE_BITS-1:0] value_q;
  logic [N_W-1:0]              n_elem;
  logic [AW-1:0]               clr_cnt, p, addr;
  logic [QW-1:0]               l, r, r_m1;
  logic [4*SW-1:0]             a_q, left, right, rdata, wdata, merged, leaf_span, final_span;
  logic [4*SW-1:0]             op_x, op_y;
  logic                        has_l, has_r;
  logic [IW-1:0]               idx_x;
  logic [AW-1:0]               leaf_addr;
  logic [CW-1:0]               n_cap;
  logic signed [SW-1:0]        v_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_elem <= N_RESET;
    end else if (cfg_we) begin
      n_elem <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind;
      index_q <= index;
      value_q <= value;
      lo_q    <= range_low;
      hi_q    <= range_high;
    end
  end

  assign idx_x     = IW'(index_q);
  assign leaf_addr = AW'(LEAF_COUNT) + AW'(idx_x[LAW-1:0]);
  assign v_ext     = SW'(value_q);
  assign leaf_span = {v_ext, v_ext, v_ext, v_ext};
  assign n_cap     = (CW'(n_elem) > CW'(LEAF_COUNT)) ? CW'(LEAF_COUNT) : CW'(n_elem);
  assign r_m1      = r - QW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_init) begin
      p <= leaf_addr >> 1;
    end else if (cmd.p_shift) begin
      p <= p >> 1;
    end
  end

  always_comb begin
    case (cmd.addr_sel)
      AS_CLEAR:   addr = clr_cnt;
      AS_LEAF:    addr = leaf_addr;
      AS_CHILD_A: addr = {p[AW-2:0], 1'b0};
      AS_CHILD_B: addr = {p[AW-2:0], 1'b1};
      AS_PARENT:  addr = p;
      AS_QL:      addr = l[AW-1:0];
      AS_QR:      addr = r_m1[AW-1:0];
      default:    addr = clr_cnt;
    endcase
  end

  // one shared merge unit; operand order follows the tree's left-to-right order
  always_comb begin
    if (cmd.l_merge) begin
      op_x = left;
      op_y = rdata;
    end else if (cmd.r_merge) begin
      op_x = rdata;
      op_y = right;
    end else if (cmd.out_load) begin
      op_x = left;
      op_y = right;
    end else begin
      op_x = a_q;
      op_y = rdata;
    end
  end
  assign merged = combine(op_x, op_y);

  always_comb begin
    case (cmd.wsel)
      WS_ZERO:  wdata = '0;
      WS_LEAF:  wdata = leaf_span;
      WS_MERGE: wdata = merged;
      default:  wdata = '0;
    endcase
  end

  rmst_ram #(.WIDTH(4 * SW), .DEPTH(2 * LEAF_COUNT)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.lat_a) begin
      a_q <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      l     <= QW'(LEAF_COUNT) + QW'(lo_q);
      r     <= QW'(LEAF_COUNT) + QW'(hi_q) + QW'(1);
      has_l <= 1'b0;
      has_r <= 1'b0;
    end else begin
      if (cmd.q_shift) begin
        l <= l >> 1;
        r <= r >> 1;
      end
      if (cmd.l_merge) begin
        left  <= has_l ? merged : rdata;
        has_l <= 1'b1;
        l     <= l + QW'(1);
      end
      if (cmd.r_merge) begin
        right <= has_r ? merged : rdata;
        has_r <= 1'b1;
        r     <= r_m1;
      end
    end
  end

  always_comb begin
    if (has_l && has_r) final_span = merged;
    else if (has_l)     final_span = left;
    else                final_span = right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_err) begin
        prefix_best <= '0;
        suffix_best <= '0;
        best_sum    <= '0;
        range_total <= '0;
        range_error <= 1'b1;
      end else begin
        prefix_best <= sat(final_span[4*SW-1:3*SW]);
        suffix_best <= sat(final_span[3*SW-1:2*SW]);
        best_sum    <= sat(final_span[2*SW-1:SW]);
        range_total <= sat(final_span[SW-1:0]);
        range_error <= 1'b0;
      end
    end
  end

  assign st.clr_last = (clr_cnt == '1);
  assign st.kind     = kind_q;
  assign st.load_oob = ({1'b0, idx_x} >= (IW + 1)'(LEAF_COUNT));
  assign st.q_err    = (lo_q > hi_q) || (CW'(hi_q) >= n_cap);
  assign st.l_lt_r   = (l < r);
  assign st.l_odd    = l[0];
  assign st.r_odd    = r[0];
  assign st.p_root   = (p == AW'(1));
endmodule

// File: rtl/core/range_max_subarray_tree_core.sv
// Top level of the range max-subarray segment tree.
// Depends on rmst_pkg, rmst_ctrl, rmst_dpath (and through it rmst_ram).
`timescale 1ns / 1ps
// Usage:
//   A transaction is taken at a clock edge with start high and busy low. kind 0
//   writes value at index and re-merges the path to the root; kind 1 queries
//   the closed range range_low..range_high.
//   A query answers with done high for exactly one cycle, carrying the four
//   sums and range_error; a load gives no answer. The receiver cannot stall:
//   results must be taken in the cycle done is high.
//   cfg_we/cfg_data set n_elements (reset 1024); write only while idle.
//   A load writes the leaf, then re-merges each tree level up to the root:
//   one RAM read of each child and one write per tree level. A query steps
//   up the levels from both range ends; each node visited takes a RAM read
//   and then a merge into the left or right partial span. A rejected range
//   answers through the dispatch state and the done register, without
//   visiting the tree. One single-port node RAM serves loads and queries.
//   After reset a clearing pass zeroes all 2*LEAF_COUNT nodes; busy stays
//   high until it ends.
module range_max_subarray_tree_core #(
  parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF,
  parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [rmst_pkg::IDX_W-1:0]        index,
  input  logic signed [VALUE_BITS-1:0]      value,
  input  logic [rmst_pkg::IDX_W-1:0]        range_low,
  input  logic [rmst_pkg::IDX_W-1:0]        range_high,
  input  logic                              cfg_we,
  input  logic [rmst_pkg::N_W-1:0]          cfg_data,
  output logic                              done,
  output logic signed [rmst_pkg::OUT_W-1:0] prefix_best,
  output logic signed [rmst_pkg::OUT_W-1:0] suffix_best,
  output logic signed [rmst_pkg::OUT_W-1:0] best_sum,
  output logic signed [rmst_pkg::OUT_W-1:0] range_total,
  output logic                              range_error
);
  import rmst_pkg::*;

  cmd_t    cmd;
  status_t st;

  rmst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  rmst_dpath #(.LEAF_COUNT(LEAF_COUNT), .VALUE_BITS(VALUE_BITS)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .kind        (kind),
    .index       (index),
    .value       (value),
    .range_low   (range_low),
    .range_high  (range_high),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .prefix_best (prefix_best),
    .suffix_best (suffix_best),
    .best_sum    (best_sum),
    .range_total (range_total),
    .range_error (range_error)
  );
endmodule

// File: rtl/core/rmst_checker.sv
// Port-level checker for range_max_subarray_tree_core, bound to the top level.
// Depends on rmst_pkg and range_max_subarray_tree_core_defines.svh.
`timescale 1ns / 1ps
`include "range_max_subarray_tree_core_defines.svh"
module rmst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [rmst_pkg::OUT_W-1:0] prefix_best,
  input logic signed [rmst_pkg::OUT_W-1:0] suffix_best,
  input logic signed [rmst_pkg::OUT_W-1:0] best_sum,
  input logic signed [rmst_pkg::OUT_W-1:0] range_total,
  input logic                              range_error
);
  import rmst_pkg::*;

  // clearing pass holds the block off right after reset
  `RMST_ASSERT_RST(a_busy_after_reset, rst, busy)
  // an accepted transaction is always worked on
  `RMST_ASSERT_NXT(a_busy_after_accept, start && !busy, busy)
  // a result is only shown once the block has gone idle
  `RMST_ASSERT_IMP(a_done_idle, done, !busy)
  // a rejected range carries zero sums
  `RMST_ASSERT_IMP(a_error_zero, done && range_error,
    prefix_best == '0 && suffix_best == '0 && best_sum == '0 && range_total == '0)
  // one result per transaction: no back-to-back strobes
  `RMST_ASSERT_NXT(a_done_single, done, !done)
endmodule

bind range_max_subarray_tree_core rmst_checker u_rmst_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .prefix_best (prefix_best),
  .suffix_best (suffix_best),
  .best_sum    (best_sum),
  .range_total (range_total),
  .range_error (range_error)
);

// File: tb/range_max_subarray_tree_core_tb.sv
// Testbench for range_max_subarray_tree_core: loads and range queries with a
// behavioral segment tree predictor. Depends on rmst_pkg and the core RTL.
`timescale 1ns / 1ps
module range_max_subarray_tree_core_tb;
  import rmst_pkg::*;

  localparam int LEAVES = 1024;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    longint pre, suf, best, tot;
  } span_s;

  typedef struct {
    logic signed [OUT_W-1:0] pre, suf, best, tot;
    logic err;
  } answer_s;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = 1'b0;
  logic [IDX_W-1:0] index = '0;
  logic signed [15:0] value = '0;
  logic [IDX_W-1:0] range_low = '0;
  logic [IDX_W-1:0] range_high = '0;
  logic cfg_we = 1'b0;
  logic [N_W-1:0] cfg_data = '0;
  logic done;
  logic signed [OUT_W-1:0] prefix_best, suffix_best, best_sum, range_total;
  logic range_error;

  range_max_subarray_tree_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .index(index), .value(value), .range_low(range_low),
    .range_high(range_high), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .done(done), .prefix_best(prefix_best), .suffix_best(suffix_best),
    .best_sum(best_sum), .range_total(range_total), .range_error(range_error)
  );

  always #5 clk = ~clk;

  span_s tree[2*LEAVES];
  int unsigned n_used = 1024;
  answer_s answers_due[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_mode = 0;

  function automatic span_s merge_spans(span_s a, span_s b);
    span_s r;
    r.pre = (a.pre > a.tot + b.pre) ? a.pre : a.tot + b.pre;
    r.suf = (b.suf > a.suf + b.tot) ? b.suf : a.suf + b.tot;
    r.best = (a.best > b.best) ? a.best : b.best;
    if (a.suf + b.pre > r.best) r.best = a.suf + b.pre;
    r.tot = a.tot + b.tot;
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_sum(longint v);
    if (v > 33554431) v = 33554431;
    if (v < -33554432) v = -33554432;
    return v[OUT_W-1:0];
  endfunction

  function automatic void tree_load(int idx, logic signed [15:0] v);
    int p;
    p = LEAVES + idx;
    tree[p].pre = v; tree[p].suf = v; tree[p].best = v; tree[p].tot = v;
    p = p >> 1;
    while (p >= 1) begin
      tree[p] = merge_spans(tree[2*p], tree[2*p+1]);
      p = p >> 1;
    end
  endfunction

  function automatic answer_s tree_query(int lo, int hi);
    answer_s a;
    span_s lft, rgt, res;
    bit hl, hr;
    int l, r, used;
    used = (n_used > LEAVES) ? LEAVES : n_used;
    hl = 0; hr = 0;
    lft = '{0, 0, 0, 0}; rgt = '{0, 0, 0, 0};
    if (lo > hi || hi >= used) begin
      a = '{'0, '0, '0, '0, 1'b1};
      return a;
    end
    l = lo + LEAVES;
    r = hi + LEAVES + 1;
    while (l < r) begin
      if (l & 1) begin
        lft = hl ? merge_spans(lft, tree[l]) : tree[l];
        hl = 1; l++;
      end
      if (r & 1) begin
        r--;
        rgt = hr ? merge_spans(tree[r], rgt) : tree[r];
        hr = 1;
      end
      l = l >> 1; r = r >> 1;
    end
    res = (hl && hr) ? merge_spans(lft, rgt) : (hl ? lft : rgt);
    a.pre = clamp_sum(res.pre); a.suf = clamp_sum(res.suf);
    a.best = clamp_sum(res.best); a.tot = clamp_sum(res.tot); a.err = 1'b0;
    return a;
  endfunction

  // result checker; the receiver never stalls
  always @(posedge clk) begin
    answer_s e;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = answers_due.pop_front();
        if (e.pre !== prefix_best || e.suf !== suffix_best || e.best !== best_sum
            || e.tot !== range_total || e.err !== range_error) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                     e.pre, e.suf, e.best, e.tot, e.err, prefix_best,
                     suffix_best, best_sum, range_total, range_error);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(logic k, int idx, int v, int lo, int hi);
    int gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1; kind <= k; index <= IDX_W'(idx); value <= 16'(v);
    range_low <= IDX_W'(lo); range_high <= IDX_W'(hi);
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    if (k == KIND_LOAD) tree_load(idx, 16'(v));
    else answers_due.push_back(tree_query(lo, hi));
    start <= 1'b0;
    // block is busy for at least this cycle after a transaction
    @(posedge clk);
  endtask

  task automatic drain();
    while (answers_due.size() != 0) @(posedge clk);
    // a load produces no result; let it finish
    repeat (40) @(posedge clk);
  endtask

  task automatic set_n_used(int n);
    drain();
    cfg_we <= 1'b1; cfg_data <= N_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_used = n;
  endtask

  task automatic test_directed();
    send_item(KIND_QUERY, 0, 0, 0, 1023);
    send_item(KIND_LOAD, 0, 16'sh7fff, 0, 0);
    send_item(KIND_LOAD, 1023, -16'sd32768, 0, 0);
    send_item(KIND_LOAD, 5, -16'sd7, 0, 0);
    send_item(KIND_LOAD, 6, 16'sd9, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 1023);
    send_item(KIND_QUERY, 0, 0, 1023, 1023);
    send_item(KIND_QUERY, 0, 0, 5, 6);
    send_item(KIND_QUERY, 0, 0, 5, 5);
    send_item(KIND_QUERY, 0, 0, 7, 3);
    send_item(KIND_QUERY, 0, 0, 0, 0);
    set_n_used(0);
    send_item(KIND_QUERY, 0, 0, 0, 0);
    set_n_used(2047);
    send_item(KIND_QUERY, 0, 0, 0, 1023);
    set_n_used(1);
    send_item(KIND_QUERY, 0, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0, 1);
    send_item(KIND_LOAD, 900, 16'sd1234, 0, 0);
    set_n_used(1024);
    send_item(KIND_QUERY, 0, 0, 900, 900);
  endtask

  task automatic test_random(int count, int nmax);
    int lo, hi;
    repeat (count) begin
      if ($urandom_range(0, 1)) begin
        // mostly small indices so queries hit loaded data
        lo = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 63);
        send_item(KIND_LOAD, lo, int'(16'($urandom())), 0, 0);
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          lo = $urandom_range(0, 1023); hi = $urandom_range(0, 1023);
        end else begin
          lo = $urandom_range(0, nmax > 0 ? nmax - 1 : 0);
          hi = $urandom_range(lo, nmax > 0 ? nmax - 1 : 0);
        end
        send_item(KIND_QUERY, 0, 0, lo, hi);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(500, 1024);
    set_n_used(64);
    test_random(500, 64);
    set_n_used(300);
    test_random(300, 300);
    set_n_used(1024);
    quiet_mode = 1;
    test_random(400, 1024);
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rmst_pkg.sv
rtl/core/rmst_ram.sv
rtl/core/rmst_ctrl.sv
rtl/core/rmst_dpath.sv
rtl/core/range_max_subarray_tree_core.sv
rtl/core/rmst_checker.sv
tb/range_max_subarray_tree_core_tb.sv
